[hdl/imn_pkg.sv]
// Shared types and constants of the inductor mean and min/max normaliser.
package imn_pkg;

	localparam int unsigned CHANNELS    = 4;
	localparam int unsigned NORM_BITS   = 7;
	localparam int unsigned LOWER_RESET = 20;
	localparam int unsigned UPPER_RESET = 100;
	localparam int unsigned SCALE       = 100;
	localparam int unsigned MIN_SPAN    = UPPER_RESET - LOWER_RESET;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_MUL,
		S_ACC,
		S_BOUND,
		S_DIV,
		S_CH_END,
		S_WRITE
	} imn_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

endpackage

[hdl/imn_in_if.sv]
// Sample channel: valid/ready handshake with one action bit and four raw samples.
interface imn_in_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic                   action;
	logic [SAMPLE_BITS-1:0] sample_left_outer;
	logic [SAMPLE_BITS-1:0] sample_left_inner;
	logic [SAMPLE_BITS-1:0] sample_right_inner;
	logic [SAMPLE_BITS-1:0] sample_right_outer;

	modport source (
		output valid, action, sample_left_outer, sample_left_inner,
		       sample_right_inner, sample_right_outer,
		input  ready
	);
	modport sink (
		input  valid, action, sample_left_outer, sample_left_inner,
		       sample_right_inner, sample_right_outer,
		output ready
	);
endinterface

[hdl/imn_out_if.sv]
// Result channel: valid/ready handshake with four means and four normalised levels.
interface imn_out_if #(
	parameter int SAMPLE_BITS = 12
);
	import imn_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] mean_left_outer;
	logic [SAMPLE_BITS-1:0] mean_left_inner;
	logic [SAMPLE_BITS-1:0] mean_right_inner;
	logic [SAMPLE_BITS-1:0] mean_right_outer;
	logic [NORM_BITS-1:0]   norm_left_outer;
	logic [NORM_BITS-1:0]   norm_left_inner;
	logic [NORM_BITS-1:0]   norm_right_inner;
	logic [NORM_BITS-1:0]   norm_right_outer;

	modport source (
		output valid, mean_left_outer, mean_left_inner, mean_right_inner,
		       mean_right_outer, norm_left_outer, norm_left_inner,
		       norm_right_inner, norm_right_outer,
		input  ready
	);
	modport sink (
		input  valid, mean_left_outer, mean_left_inner, mean_right_inner,
		       mean_right_outer, norm_left_outer, norm_left_inner,
		       norm_right_inner, norm_right_outer,
		output ready
	);
endinterface

[hdl/imn_window_mem.sv]
// Ring window store: one row of per-channel quotients per slot, with row valid bits.
module imn_window_mem #(
	parameter int DEPTH  = 10,
	parameter int ROW_W  = 48,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [ROW_W-1:0]  rd_data,
	output logic              rd_valid,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ROW_W-1:0]  wr_data
);

	logic [ROW_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [ROW_W-1:0] rd_data_q;
	logic             rd_valid_q;

	// write and read the array; data is registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// track which rows hold written data; a read of a row not yet written returns rd_valid low
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

[hdl/imn_div_unit.sv]
// Shared restoring divider: one quotient bit per step, quotient below 2**NORM_BITS.
module imn_div_unit #(
	parameter int NUM_W = 19
) (
	input  logic                     clk,
	input  imn_pkg::div_ctl_t        ctl,
	input  logic [NUM_W-1:0]         num,
	input  logic [NUM_W-1:0]         span,
	output logic [imn_pkg::NORM_BITS-1:0] quot
);
	import imn_pkg::*;

	logic [NUM_W-1:0]     rem_q;
	logic [NUM_W-1:0]     den_q;
	logic [NORM_BITS-1:0] quot_q;
	logic                 fits;

	assign fits = (rem_q >= den_q);

	// load operands with the divisor aligned to the top quotient bit, then step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q  <= num;
			den_q  <= span << (NORM_BITS - 1);
			quot_q <= '0;
		end else if (ctl.step) begin
			if (fits) begin
				rem_q <= rem_q - den_q;
			end
			den_q  <= den_q >> 1;
			quot_q <= {quot_q[NORM_BITS-2:0], fits};
		end
	end

	assign quot = quot_q;

endmodule

[hdl/inductor_mean_minmax_normalizer_core.sv]
// Top level: windowed means of four inductor channels with min/max normalisation.
//
// Use: each transfer on 'samples' carries an action bit and one raw sample per
// channel. The samples go into a WINDOW_DEPTH-deep ring window per channel; the
// mean is the sum of the stored samples each divided by WINDOW_DEPTH. On a
// measure item (action = 1) each channel's lower or upper bound follows the mean
// and the level (mean - lower) * 100 / (upper - lower) is returned; a preload
// item only fills the window and returns the means with zero levels.
// One result transfer on 'results' follows every sample transfer.
// Sequence: a transfer moves the block from idle to a window read, then through
// each channel in turn, then to the result write-back and back to idle; a new
// item is taken only after the last one's write-back. 'samples.ready' is high
// only between items. The per-channel sequence (reciprocal multiply, running-sum
// update, bound update and seven steps of the shared divider) runs one channel
// after the other; a preload item skips the bound update and the divider.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled receiver holds the block only at the final write-back.
// Reset: windows read as zero, bounds return to 20 and 100, write index to 0;
// the block is ready as soon as reset is released.
module inductor_mean_minmax_normalizer_core #(
	parameter int WINDOW_DEPTH = 10,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	imn_in_if.sink    samples,
	imn_out_if.source results
);
	import imn_pkg::*;

	localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CH_W    = $clog2(CHANNELS);
	localparam int CNT_W   = $clog2(NORM_BITS);
	localparam int ROW_W   = CHANNELS * SAMPLE_BITS;
	localparam int NUM_W   = SAMPLE_BITS + NORM_BITS;
	localparam int SHIFT   = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
	localparam int RECIP_W = SAMPLE_BITS + 1;
	localparam int PROD_W  = SAMPLE_BITS + RECIP_W;
	localparam int RECIP   = ((1 << SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

	localparam logic [RECIP_W-1:0] RECIP_V  = RECIP_W'(RECIP);
	localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
	localparam logic [CH_W-1:0]    CH_LAST  = CH_W'(CHANNELS - 1);
	localparam logic [CNT_W-1:0]   DIV_LAST = CNT_W'(NORM_BITS - 1);

	imn_state_t state_q, state_d;

	logic                                  action_q;
	logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  samp_q;
	logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  sum_q;
	logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  lo_q;
	logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  hi_q;
	logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  new_row_q;
	logic [CHANNELS-1:0][NORM_BITS-1:0]    norm_q;
	logic [SAMPLE_BITS-1:0]                quo_q;
	logic [CH_W-1:0]                       ch_q;
	logic [CNT_W-1:0]                      cnt_q;
	logic [IDX_W-1:0]                      idx_q;
	logic                                  out_valid_q;
	logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  mean_out_q;
	logic [CHANNELS-1:0][NORM_BITS-1:0]    norm_out_q;

	logic             in_ready;
	logic             mem_rd;
	logic             out_load;
	div_ctl_t         div_ctl;
	logic [ROW_W-1:0] rd_row;
	logic             rd_valid;

	logic [PROD_W-1:0]      prod;
	logic [SAMPLE_BITS-1:0] old_quo;
	logic [SAMPLE_BITS-1:0] mean;
	logic [SAMPLE_BITS-1:0] lo_nx;
	logic [SAMPLE_BITS-1:0] hi_nx;
	logic [NUM_W-1:0]       div_num;
	logic [NUM_W-1:0]       div_span;
	logic [NORM_BITS-1:0]   div_quot;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (samples.valid) begin
					state_d = S_READ;
				end
			end
			S_READ:  state_d = S_MUL;
			S_MUL:   state_d = S_ACC;
			S_ACC:   state_d = action_q ? S_BOUND : S_CH_END;
			S_BOUND: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = S_CH_END;
				end
			end
			S_CH_END: state_d = (ch_q == CH_LAST) ? S_WRITE : S_MUL;
			S_WRITE: begin
				if (!out_valid_q || results.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		in_ready     = 1'b0;
		mem_rd       = 1'b0;
		out_load     = 1'b0;
		div_ctl.load = 1'b0;
		div_ctl.step = 1'b0;
		unique case (state_q)
			S_IDLE:  in_ready     = 1'b1;
			S_READ:  mem_rd       = 1'b1;
			S_BOUND: div_ctl.load = 1'b1;
			S_DIV:   div_ctl.step = 1'b1;
			S_WRITE: out_load     = !out_valid_q || results.ready;
			default: ;
		endcase
	end

	assign samples.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window store shared by the four channels
	imn_window_mem #(
		.DEPTH  (WINDOW_DEPTH),
		.ROW_W  (ROW_W),
		.ADDR_W (IDX_W)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (mem_rd),
		.rd_addr  (idx_q),
		.rd_data  (rd_row),
		.rd_valid (rd_valid),
		.wr_en    (out_load),
		.wr_addr  (idx_q),
		.wr_data  (new_row_q)
	);

	// sample / depth by reciprocal multiply, exact over the sample range
	assign prod    = PROD_W'(samp_q[ch_q]) * PROD_W'(RECIP_V);
	assign old_quo = rd_valid ? rd_row[ch_q*SAMPLE_BITS +: SAMPLE_BITS] : '0;

	// bound update and divider operands
	assign mean  = sum_q[ch_q];
	assign lo_nx = (mean < lo_q[ch_q]) ? mean : lo_q[ch_q];
	assign hi_nx = (mean >= lo_q[ch_q] && mean > hi_q[ch_q]) ? mean : hi_q[ch_q];
	assign div_num  = NUM_W'(mean - lo_nx) * NUM_W'(SCALE);
	assign div_span = NUM_W'(hi_nx - lo_nx);

	imn_div_unit #(
		.NUM_W (NUM_W)
	) u_div (
		.clk  (clk),
		.ctl  (div_ctl),
		.num  (div_num),
		.span (div_span),
		.quot (div_quot)
	);

	// capture the item and run the per-channel datapath
	always_ff @(posedge clk) begin
		if (samples.valid && in_ready) begin
			action_q  <= samples.action;
			samp_q[0] <= samples.sample_left_outer;
			samp_q[1] <= samples.sample_left_inner;
			samp_q[2] <= samples.sample_right_inner;
			samp_q[3] <= samples.sample_right_outer;
		end
		if (state_q == S_MUL) begin
			quo_q <= SAMPLE_BITS'(prod >> SHIFT);
		end
		if (state_q == S_ACC) begin
			new_row_q[ch_q] <= quo_q;
		end
		if (state_q == S_CH_END) begin
			norm_q[ch_q] <= action_q ? div_quot : '0;
		end
		if (out_load) begin
			mean_out_q <= sum_q;
			norm_out_q <= norm_q;
		end
	end

	// running sums, bounds, counters and write index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				sum_q[c] <= '0;
				lo_q[c]  <= SAMPLE_BITS'(LOWER_RESET);
				hi_q[c]  <= SAMPLE_BITS'(UPPER_RESET);
			end
			ch_q        <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_READ) begin
				ch_q <= '0;
			end
			if (state_q == S_ACC) begin
				sum_q[ch_q] <= sum_q[ch_q] - old_quo + quo_q;
			end
			if (state_q == S_BOUND) begin
				lo_q[ch_q] <= lo_nx;
				hi_q[ch_q] <= hi_nx;
				cnt_q      <= '0;
			end
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == S_CH_END) begin
				ch_q <= ch_q + 1'b1;
			end
			if (out_load) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register onto the channel
	assign results.valid            = out_valid_q;
	assign results.mean_left_outer  = mean_out_q[0];
	assign results.mean_left_inner  = mean_out_q[1];
	assign results.mean_right_inner = mean_out_q[2];
	assign results.mean_right_outer = mean_out_q[3];
	assign results.norm_left_outer  = norm_out_q[0];
	assign results.norm_left_inner  = norm_out_q[1];
	assign results.norm_right_inner = norm_out_q[2];
	assign results.norm_right_outer = norm_out_q[3];

`ifndef SYNTHESIS
	// tracked span never shrinks below its reset width
	assert property (@(posedge clk) disable iff (!arst_n)
		(hi_q[0] - lo_q[0]) >= SAMPLE_BITS'(MIN_SPAN) &&
		(hi_q[1] - lo_q[1]) >= SAMPLE_BITS'(MIN_SPAN) &&
		(hi_q[2] - lo_q[2]) >= SAMPLE_BITS'(MIN_SPAN) &&
		(hi_q[3] - lo_q[3]) >= SAMPLE_BITS'(MIN_SPAN))
		else $error("bound span below minimum");

	// levels stay within percent range
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |->
			(results.norm_left_outer  <= NORM_BITS'(SCALE)) &&
			(results.norm_left_inner  <= NORM_BITS'(SCALE)) &&
			(results.norm_right_inner <= NORM_BITS'(SCALE)) &&
			(results.norm_right_outer <= NORM_BITS'(SCALE)))
		else $error("normalised level above 100");

	// a sample transfer starts the sequence and blocks the next one
	assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> (state_q == S_READ && !samples.ready))
		else $error("sample transfer did not start the sequence");

	// the result register is loaded only once the previous result has left
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || results.ready) && (state_q == S_WRITE))
		else $error("result overwritten before transfer");
`endif

endmodule
